/* sv/base64url_stream_decoder_macros.svh */
// Assertion macros shared by the base64url stream decoder files.
`ifndef BASE64URL_STREAM_DECODER_MACROS_SVH
`define BASE64URL_STREAM_DECODER_MACROS_SVH

`ifndef SYNTHESIS
`define B64_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("b64 assertion failed");
`define B64_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("b64 assertion failed");
`else
`define B64_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define B64_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* sv/b64_pkg.sv */
// Types, constants and the character classifier of the base64url stream decoder.
package b64_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam logic [23:0] CountMax = 24'hFFFFFF;

  typedef enum logic [1:0] {
    ST_BYTE = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_DONE,
    TAIL_ERR
  } tail_t;

  typedef enum logic [1:0] {
    KIND_ALPHA,
    KIND_SPACE,
    KIND_BAD
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [5:0] value;
  } class_t;

  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      nbytes;
    tail_t           tail;
    logic [23:0]     total;
  } job_t;

  function automatic class_t classify(input logic [7:0] c);
    class_t r;
    r.kind  = KIND_BAD;
    r.value = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.kind  = KIND_ALPHA;
      r.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.kind  = KIND_ALPHA;
      r.value = 6'(c - 8'd71);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.kind  = KIND_ALPHA;
      r.value = 6'(c + 8'd4);
    end else if (c == 8'h2D) begin
      r.kind  = KIND_ALPHA;
      r.value = 6'd62;
    end else if (c == 8'h5F) begin
      r.kind  = KIND_ALPHA;
      r.value = 6'd63;
    end else if (c == 8'h20 || c == 8'h0A || c == 8'h09) begin
      r.kind  = KIND_SPACE;
    end
    return r;
  endfunction

endpackage

/* sv/b64_front.sv */
// Front end: classifies characters, gathers sextets and builds result jobs.
module b64_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    in_char_i,
  input  logic          in_final_i,
  input  logic          accept_i,
  output b64_pkg::job_t job_o,
  output logic          job_valid_o
);
  import b64_pkg::*;

  logic [17:0] accum_r, accum_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        skip_r, skip_nxt;
  logic [23:0] bytes_r, bytes_nxt;

  class_t      cls;
  job_t        job;
  logic [23:0] grp;
  logic [17:0] sh_acc;
  logic [1:0]  sh_cnt;
  logic [24:0] sum;
  logic [23:0] sat;

  always_comb begin
    cls         = classify(in_char_i);
    accum_nxt   = accum_r;
    cnt_nxt     = cnt_r;
    skip_nxt    = skip_r;
    bytes_nxt   = bytes_r;
    job.data    = '0;
    job.nbytes  = 2'd0;
    job.tail    = TAIL_NONE;
    job.total   = 24'd0;
    grp         = {accum_r, cls.value};
    sh_acc      = accum_r;
    sh_cnt      = cnt_r;
    sum         = 25'd0;
    sat         = 24'd0;
    if (skip_r) begin
      if (in_final_i) begin
        accum_nxt = '0;
        cnt_nxt   = '0;
        skip_nxt  = 1'b0;
        bytes_nxt = '0;
      end
    end else if (cls.kind == KIND_BAD) begin
      job.tail = TAIL_ERR;
      if (in_final_i) begin
        accum_nxt = '0;
        cnt_nxt   = '0;
        bytes_nxt = '0;
      end else begin
        skip_nxt = 1'b1;
      end
    end else begin
      if (cls.kind == KIND_ALPHA) begin
        if (cnt_r == 2'd3) begin
          job.data[0] = grp[23:16];
          job.data[1] = grp[15:8];
          job.data[2] = grp[7:0];
          job.nbytes  = 2'd3;
          sh_acc      = '0;
          sh_cnt      = 2'd0;
        end else begin
          sh_acc = {accum_r[11:0], cls.value};
          sh_cnt = cnt_r + 2'd1;
        end
      end
      if (in_final_i) begin
        case (sh_cnt)
          2'd1: job.tail = TAIL_ERR;
          2'd2: begin
            job.data[0] = sh_acc[11:4];
            job.nbytes  = 2'd1;
            job.tail    = TAIL_DONE;
          end
          2'd3: begin
            job.data[0] = sh_acc[17:10];
            job.data[1] = sh_acc[9:2];
            job.nbytes  = 2'd2;
            job.tail    = TAIL_DONE;
          end
          default: job.tail = TAIL_DONE;
        endcase
      end
      sum       = {1'b0, bytes_r} + 25'(job.nbytes);
      sat       = sum[24] ? CountMax : sum[23:0];
      job.total = sat;
      if (in_final_i) begin
        accum_nxt = '0;
        cnt_nxt   = '0;
        bytes_nxt = '0;
      end else begin
        accum_nxt = sh_acc;
        cnt_nxt   = sh_cnt;
        bytes_nxt = sat;
      end
    end
  end

  assign job_o       = job;
  assign job_valid_o = accept_i && ((job.nbytes != 2'd0) || (job.tail != TAIL_NONE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
      cnt_r   <= '0;
      skip_r  <= 1'b0;
      bytes_r <= '0;
    end else if (accept_i) begin
      accum_r <= accum_nxt;
      cnt_r   <= cnt_nxt;
      skip_r  <= skip_nxt;
      bytes_r <= bytes_nxt;
    end
  end

endmodule

/* sv/b64_fifo.sv */
// Short job queue between the front end and the result sequencer.
`include "base64url_stream_decoder_macros.svh"
module b64_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_i,
  input  b64_pkg::job_t push_job_i,
  input  logic          pop_i,
  output b64_pkg::job_t head_o,
  output logic          full_o,
  output logic          empty_o
);
  import b64_pkg::*;

  job_t            slots_r [QueueDepth];
  logic [PtrW:0]   wr_r, wr_nxt;
  logic [PtrW:0]   rd_r, rd_nxt;

  assign empty_o = (wr_r == rd_r);
  assign full_o  = (wr_r[PtrW] != rd_r[PtrW]) && (wr_r[PtrW-1:0] == rd_r[PtrW-1:0]);
  assign head_o  = slots_r[rd_r[PtrW-1:0]];
  assign wr_nxt  = wr_r + (PtrW+1)'(push_i && !full_o);
  assign rd_nxt  = rd_r + (PtrW+1)'(pop_i && !empty_o);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i && !full_o) begin
      slots_r[wr_r[PtrW-1:0]] <= push_job_i;
    end
  end

  `B64_ASSERT_IMPL(a_no_push_when_full, clk, rst_n, full_o, !push_i)
  `B64_ASSERT_NEXT(a_push_fills, clk, rst_n, push_i && !full_o, !empty_o)

endmodule

/* sv/b64_back.sv */
// Result sequencer: expands each job into result words behind an output register.
`include "base64url_stream_decoder_macros.svh"
module b64_back (
  input  logic          clk,
  input  logic          rst_n,
  input  b64_pkg::job_t job_i,
  input  logic          job_empty_i,
  output logic          job_pop_o,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_data_byte,
  output logic [1:0]    out_status,
  output logic [23:0]   out_total_bytes,
  output logic          out_run_end
);
  import b64_pkg::*;

  logic        valid_r;
  logic [1:0]  idx_r, idx_nxt;
  logic [7:0]  byte_r, byte_nxt;
  status_t     status_r, status_nxt;
  logic [23:0] total_r, total_nxt;
  logic        end_r, end_nxt;

  logic [2:0]  count;
  logic        last;
  logic        advance;
  logic        load;

  always_comb begin
    count      = {1'b0, job_i.nbytes} + 3'(job_i.tail != TAIL_NONE);
    last       = ({1'b0, idx_r} == (count - 3'd1));
    advance    = !valid_r || pop;
    load       = advance && !job_empty_i;
    idx_nxt    = idx_r;
    byte_nxt   = 8'd0;
    status_nxt = ST_BYTE;
    total_nxt  = 24'd0;
    end_nxt    = last;
    if ({1'b0, idx_r} < {1'b0, job_i.nbytes}) begin
      case (idx_r)
        2'd0:    byte_nxt = job_i.data[0];
        2'd1:    byte_nxt = job_i.data[1];
        default: byte_nxt = job_i.data[2];
      endcase
    end else if (job_i.tail == TAIL_DONE) begin
      status_nxt = ST_DONE;
      total_nxt  = job_i.total;
    end else begin
      status_nxt = ST_ERR;
    end
    if (load) begin
      idx_nxt = last ? 2'd0 : idx_r + 2'd1;
    end
  end

  assign job_pop_o       = load && last;
  assign empty           = !valid_r;
  assign out_data_byte   = byte_r;
  assign out_status      = status_r;
  assign out_total_bytes = total_r;
  assign out_run_end     = end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (advance) begin
        valid_r <= !job_empty_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= byte_nxt;
      status_r <= status_nxt;
      total_r  <= total_nxt;
      end_r    <= end_nxt;
    end
  end

  `B64_ASSERT_IMPL(a_idx_needs_job, clk, rst_n, idx_r != 2'd0, !job_empty_i)
  `B64_ASSERT_IMPL(a_tail_ends_run, clk, rst_n, valid_r && status_r != ST_BYTE, end_r)

endmodule

/* sv/base64url_stream_decoder.sv */
// Top level of the base64url stream decoder: front end, job queue and result sequencer.
//
//   channel  | ports                                                  | handshake
//   ---------+--------------------------------------------------------+-----------
//   input    | in_text_char, in_final_char                            | push / full
//   result   | out_data_byte, out_status, out_total_bytes, out_run_end | empty / pop
//
// One character is accepted every cycle while full is low.
// The result sequencer delivers one word per cycle while pop is high and keeps each job until
// its last word is loaded; a four-entry job queue absorbs bursts; full rises when it fills.
// With the queue and sequencer idle, a word passes through the job queue and then the output
// register before it reaches the result ports.
// Synchronous reset clears decoder state, the queue and the output valid flag.
module base64url_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_text_char,
  input  logic        in_final_char,
  input  logic        push,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_data_byte,
  output logic [1:0]  out_status,
  output logic [23:0] out_total_bytes,
  output logic        out_run_end
);
  import b64_pkg::*;

  job_t job_in;
  job_t job_head;
  logic job_push;
  logic job_pop;
  logic job_empty;
  logic accept;

  assign accept = push && !full;

  b64_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_char_i  (in_text_char),
    .in_final_i (in_final_char),
    .accept_i   (accept),
    .job_o      (job_in),
    .job_valid_o(job_push)
  );

  b64_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (job_push),
    .push_job_i(job_in),
    .pop_i     (job_pop),
    .head_o    (job_head),
    .full_o    (full),
    .empty_o   (job_empty)
  );

  b64_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_i          (job_head),
    .job_empty_i    (job_empty),
    .job_pop_o      (job_pop),
    .pop            (pop),
    .empty          (empty),
    .out_data_byte  (out_data_byte),
    .out_status     (out_status),
    .out_total_bytes(out_total_bytes),
    .out_run_end    (out_run_end)
  );

endmodule

/* dv/tb.sv */
// Self-checking testbench for the base64url stream decoder.
`timescale 1ns / 100ps

module tb;
  import b64_pkg::*;

  localparam int SkipCode = 64;
  localparam int BadCode  = 65;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
    int         gap;
    bit         drain;
  } text_item_t;

  typedef struct {
    logic [7:0]  data;
    status_t     status;
    logic [23:0] total;
    logic        run_end;
  } dec_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [7:0]  in_text_char = 8'h00;
  logic        in_final_char = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_data_byte;
  logic [1:0]  out_status;
  logic [23:0] out_total_bytes;
  logic        out_run_end;

  text_item_t char_queue[$];
  dec_word_t  exp_words[$];

  logic [17:0] dec_acc = '0;
  logic [1:0]  dec_cnt = '0;
  logic        dec_skip = 1'b0;
  logic [23:0] dec_total = '0;

  int idle_left = 0;
  int stall_left = 0;
  bit hold_done = 1'b0;
  int chars_taken = 0;
  int texts_taken = 0;
  int words_seen = 0;
  int errors = 0;

  base64url_stream_decoder i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_text_char    (in_text_char),
    .in_final_char   (in_final_char),
    .push            (push),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .out_data_byte   (out_data_byte),
    .out_status      (out_status),
    .out_total_bytes (out_total_bytes),
    .out_run_end     (out_run_end)
  );

  always #6 clk = ~clk;

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [7:0] sextet_char(input int v);
    if (v < 26) begin
      return 8'(v + 65);
    end else if (v < 52) begin
      return 8'(v - 26 + 97);
    end else if (v < 62) begin
      return 8'(v - 52 + 48);
    end else if (v == 62) begin
      return 8'h2D;
    end
    return 8'h5F;
  endfunction

  function automatic int char_sextet(input logic [7:0] c);
    if (c >= "A" && c <= "Z") begin
      return int'(c) - 65;
    end else if (c >= "a" && c <= "z") begin
      return int'(c) - 97 + 26;
    end else if (c >= "0" && c <= "9") begin
      return int'(c) - 48 + 52;
    end else if (c == "-") begin
      return 62;
    end else if (c == "_") begin
      return 63;
    end else if (c == 8'h20 || c == 8'h0A || c == 8'h09) begin
      return SkipCode;
    end
    return BadCode;
  endfunction

  function automatic dec_word_t make_word(input logic [7:0] data, input status_t st,
                                          input logic [23:0] total);
    dec_word_t w;
    w.data = data;
    w.status = st;
    w.total = total;
    w.run_end = 1'b0;
    return w;
  endfunction

  task automatic clear_decoder();
    dec_acc = '0;
    dec_cnt = '0;
    dec_skip = 1'b0;
    dec_total = '0;
  endtask

  task automatic predict_decode(input logic [7:0] ch, input logic fin);
    dec_word_t words[$];
    int v;
    logic [23:0] grp;
    logic [7:0] bytes[$];
    if (dec_skip) begin
      if (fin) clear_decoder();
      return;
    end
    v = char_sextet(ch);
    if (v == BadCode) begin
      words.push_back(make_word(8'h00, ST_ERR, 24'd0));
      if (fin) begin
        clear_decoder();
      end else begin
        dec_skip = 1'b1;
      end
    end else begin
      if (v < SkipCode) begin
        if (dec_cnt == 2'd3) begin
          grp = {dec_acc, v[5:0]};
          bytes.push_back(grp[23:16]);
          bytes.push_back(grp[15:8]);
          bytes.push_back(grp[7:0]);
          dec_acc = '0;
          dec_cnt = '0;
        end else begin
          dec_acc = {dec_acc[11:0], v[5:0]};
          dec_cnt = dec_cnt + 2'd1;
        end
      end
      if (fin && dec_cnt == 2'd2) begin
        bytes.push_back(dec_acc[11:4]);
      end else if (fin && dec_cnt == 2'd3) begin
        bytes.push_back(dec_acc[17:10]);
        bytes.push_back(dec_acc[9:2]);
      end
      foreach (bytes[i]) begin
        words.push_back(make_word(bytes[i], ST_BYTE, 24'd0));
        if (dec_total != CountMax) dec_total = dec_total + 24'd1;
      end
      if (fin) begin
        if (dec_cnt == 2'd1) begin
          words.push_back(make_word(8'h00, ST_ERR, 24'd0));
        end else begin
          words.push_back(make_word(8'h00, ST_DONE, dec_total));
        end
        clear_decoder();
      end
    end
    if (words.size() > 0) words[words.size() - 1].run_end = 1'b1;
    foreach (words[i]) exp_words.push_back(words[i]);
  endtask

  task automatic add_char(input logic [7:0] ch, input logic fin);
    text_item_t it;
    int idx;
    idx = char_queue.size();
    it.ch = ch;
    it.fin = fin;
    it.drain = (idx == 27 || idx == 170);
    if ((idx >= 30 && idx < 130) || (idx / 40) % 4 == 2) begin
      it.gap = 0;
    end else begin
      it.gap = pick_idle();
    end
    char_queue.push_back(it);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      add_char(s[i], i == s.len() - 1);
    end
  endtask

  // Driver: offers the queued characters and predicts each accepted one.
  always @(posedge clk) begin
    bit busy;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      busy = push;
      if (push && !full) begin
        predict_decode(in_text_char, in_final_char);
        chars_taken++;
        if (in_final_char) texts_taken++;
        void'(char_queue.pop_front());
        if (char_queue.size() > 0) idle_left = char_queue[0].gap;
        busy = 1'b0;
      end
      if (!busy) begin
        if (idle_left > 0) begin
          idle_left--;
          push <= 1'b0;
        end else if (char_queue.size() > 0 &&
                     !(char_queue[0].drain && exp_words.size() != 0)) begin
          push <= 1'b1;
          in_text_char <= char_queue[0].ch;
          in_final_char <= char_queue[0].fin;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes result words and compares them with the predicted ones.
  always @(posedge clk) begin
    dec_word_t want;
    bit calm;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      calm = (words_seen / 40) % 3 == 1;
      if (pop && !empty) begin
        words_seen++;
        if (exp_words.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected word: byte %02h status %0d total %0d end %0b",
                     out_data_byte, out_status, out_total_bytes, out_run_end);
          end
        end else begin
          want = exp_words.pop_front();
          if (out_data_byte !== want.data || out_status !== want.status ||
              out_total_bytes !== want.total || out_run_end !== want.run_end) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: expected %02h %0d %0d %0b, got %02h %0d %0d %0b",
                       want.data, want.status, want.total, want.run_end,
                       out_data_byte, out_status, out_total_bytes, out_run_end);
            end
          end
        end
        if (!calm) stall_left = pick_idle();
      end
      if (!hold_done && chars_taken >= 40) begin
        hold_done = 1'b1;
        stall_left = 70;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    int len;
    int r;
    bit noisy;
    logic [7:0] ch;
    add_text("AZaz09-_");
    add_text("___\t");
    add_text("AAAA\n");
    add_text("Q");
    add_text("A*B");
    add_text("AB=");
    add_text(" ");
    add_char(8'h00, 1'b0);
    add_char(8'hFF, 1'b1);
    while (char_queue.size() < 215) begin
      len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 18);
      noisy = $urandom_range(0, 9) == 0;
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (noisy && r < 8) begin
          ch = 8'($urandom_range(0, 255));
        end else if (r < 10) begin
          case ($urandom_range(0, 2))
            0: ch = 8'h20;
            1: ch = 8'h0A;
            default: ch = 8'h09;
          endcase
        end else begin
          ch = sextet_char($urandom_range(0, 63));
        end
        add_char(ch, 1'b0);
      end
      r = $urandom_range(0, 99);
      if (len > 0 && r < 60) begin
        char_queue[char_queue.size() - 1].fin = 1'b1;
      end else if (r < 95) begin
        add_char(($urandom_range(0, 1) == 0) ? 8'h20 : 8'h0A, 1'b1);
      end else begin
        add_char(8'($urandom_range(0, 255)), 1'b1);
      end
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait (char_queue.size() == 0 && !push);
    wait (exp_words.size() == 0);
    repeat (20) @(posedge clk);
    $display("Decoded %0d characters in %0d texts; %0d result words checked, %0d mismatches.",
             chars_taken, texts_taken, words_seen, errors);
    if (errors == 0 && exp_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

endmodule
